### design/psfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psfp_pkg
// Shared constants and types of the particle sensor frame parser.
// ----------------------------------------------------------------------------
package psfp_pkg;

  localparam int unsigned FrameLen     = 32;
  localparam int unsigned SumBytes     = 30;
  localparam int unsigned WordFirst    = 4;
  localparam int unsigned WordCount    = 12;
  localparam int unsigned PosWidth     = 6;
  localparam int unsigned IdxWidth     = 4;

  localparam logic [7:0] HeaderFirst   = 8'h42;
  localparam logic [7:0] HeaderSecond  = 8'h4D;

  localparam logic [PosWidth-1:0] PosFirstWord = PosWidth'(WordFirst);
  localparam logic [PosWidth-1:0] PosLastWord  = PosWidth'(WordFirst + 2 * WordCount - 1);
  localparam logic [PosWidth-1:0] PosLastSum   = PosWidth'(SumBytes - 1);
  localparam logic [PosWidth-1:0] PosSumHigh   = PosWidth'(SumBytes);
  localparam logic [PosWidth-1:0] PosLast      = PosWidth'(FrameLen - 1);
  localparam logic [IdxWidth-1:0] IdxLast      = IdxWidth'(WordCount - 1);
  localparam logic [IdxWidth-1:0] WordBase     = IdxWidth'(WordFirst / 2);

  typedef logic [1:0] status_t;
  localparam status_t StatusOk       = 2'd0;
  localparam status_t StatusHeader   = 2'd1;
  localparam status_t StatusChecksum = 2'd2;

  typedef struct packed {
    logic [WordCount-1:0][15:0] words;
    status_t                    status;
  } frame_result_t;

endpackage
`default_nettype wire

### design/psfp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psfp_in_if / psfp_out_if
// Valid/ready channels for received bytes and parsed measurement results.
// ----------------------------------------------------------------------------
interface psfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface psfp_out_if;
  logic                 valid;
  logic                 ready;
  logic [3:0]           field_index;
  logic [15:0]          field_value;
  psfp_pkg::status_t    frame_status;
  logic                 last_field;

  modport source (output valid, output field_index, output field_value,
                  output frame_status, output last_field, input ready);
  modport sink   (input valid, input field_index, input field_value,
                  input frame_status, input last_field, output ready);
endinterface
`default_nettype wire

### design/psfp_accum.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psfp_accum
// Byte position tracking, checksum, header check and word assembly.
// ----------------------------------------------------------------------------
module psfp_accum (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  psfp_in_if.sink                      in_ch,
  input  wire logic                    burst_pending,
  output logic                         done,
  output psfp_pkg::frame_result_t      result
);

  logic [psfp_pkg::PosWidth-1:0] pos_r, pos_nxt, p;
  logic [15:0]                   sum_r, sum_nxt;
  logic                          hdr_r, hdr_nxt;
  logic [7:0]                    latch_r, latch_nxt;
  logic [15:0]                   words_r [psfp_pkg::WordCount];
  logic                          xfer, active, word_wr;
  logic [psfp_pkg::IdxWidth-1:0] word_idx;
  logic [15:0]                   rx_sum;

  // stall only a closing byte while the previous burst still drains
  assign in_ch.ready = !(burst_pending && (pos_r == psfp_pkg::PosLast));
  assign xfer        = in_ch.valid && in_ch.ready;

  assign p        = in_ch.frame_start ? '0 : pos_r;
  assign active   = !p[psfp_pkg::PosWidth-1];
  assign word_wr  = active && p[0] && (p >= psfp_pkg::PosFirstWord)
                    && (p <= psfp_pkg::PosLastWord);
  assign word_idx = p[psfp_pkg::IdxWidth:1] - psfp_pkg::WordBase;
  assign rx_sum   = {latch_r, in_ch.rx_byte};
  assign done     = xfer && active && (p == psfp_pkg::PosLast);

  always_comb begin
    pos_nxt   = pos_r;
    sum_nxt   = sum_r;
    hdr_nxt   = hdr_r;
    latch_nxt = latch_r;
    if (xfer) begin
      pos_nxt = p;
      if (active) begin
        pos_nxt = p + 1'b1;
        if (p == '0) begin
          sum_nxt = {8'd0, in_ch.rx_byte};
          hdr_nxt = (in_ch.rx_byte == psfp_pkg::HeaderFirst);
        end else if (p <= psfp_pkg::PosLastSum) begin
          sum_nxt = sum_r + {8'd0, in_ch.rx_byte};
          if (p == psfp_pkg::PosWidth'(1)) begin
            hdr_nxt = hdr_r && (in_ch.rx_byte == psfp_pkg::HeaderSecond);
          end
        end
        if (!p[0] && (((p >= psfp_pkg::PosFirstWord) && (p <= psfp_pkg::PosLastWord))
                      || (p == psfp_pkg::PosSumHigh))) begin
          latch_nxt = in_ch.rx_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      sum_r   <= '0;
      hdr_r   <= 1'b0;
      latch_r <= '0;
    end else begin
      pos_r   <= pos_nxt;
      sum_r   <= sum_nxt;
      hdr_r   <= hdr_nxt;
      latch_r <= latch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (xfer && word_wr) begin
      words_r[word_idx] <= {latch_r, in_ch.rx_byte};
    end
  end

  always_comb begin
    for (int i = 0; i < psfp_pkg::WordCount; i++) begin
      result.words[i] = words_r[i];
    end
    priority if (!hdr_r) begin
      result.status = psfp_pkg::StatusHeader;
    end else if (sum_r != rx_sum) begin
      result.status = psfp_pkg::StatusChecksum;
    end else begin
      result.status = psfp_pkg::StatusOk;
    end
  end

endmodule
`default_nettype wire

### design/psfp_burst.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psfp_burst
// Frame result buffer and output register; drains twelve words per frame.
// ----------------------------------------------------------------------------
module psfp_burst (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    load,
  input  wire psfp_pkg::frame_result_t result,
  output logic                         pending,
  psfp_out_if.source                   out_ch
);

  logic [15:0]                   buf_r [psfp_pkg::WordCount];
  psfp_pkg::status_t             status_r;
  logic [psfp_pkg::IdxWidth-1:0] idx_r;
  logic                          pend_r;
  logic                          out_valid_r;
  logic [3:0]                    out_index_r;
  logic [15:0]                   out_value_r;
  psfp_pkg::status_t             out_status_r;
  logic                          out_last_r;
  logic                          adv, ok;

  assign pending = pend_r;
  assign adv     = !out_valid_r || out_ch.ready;
  assign ok      = (result.status == psfp_pkg::StatusOk);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (load) begin
        pend_r <= 1'b1;
        idx_r  <= '0;
      end else if (pend_r && adv) begin
        idx_r <= idx_r + 1'b1;
        if (idx_r == psfp_pkg::IdxLast) begin
          pend_r <= 1'b0;
        end
      end
      if (adv) begin
        out_valid_r <= pend_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_r <= result.status;
      for (int i = 0; i < psfp_pkg::WordCount; i++) begin
        buf_r[i] <= ok ? result.words[i] : 16'd0;
      end
    end
    if (pend_r && adv) begin
      out_index_r  <= idx_r;
      out_value_r  <= buf_r[idx_r];
      out_status_r <= status_r;
      out_last_r   <= (idx_r == psfp_pkg::IdxLast);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.field_index  = out_index_r;
  assign out_ch.field_value  = out_value_r;
  assign out_ch.frame_status = out_status_r;
  assign out_ch.last_field   = out_last_r;

endmodule
`default_nettype wire

### design/particle_sensor_frame_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// particle_sensor_frame_parser
// Parses 32-byte particulate sensor response frames into twelve results.
//
// in_ch carries one received byte per transfer; frame_start marks byte 0.
// Bytes after a completed frame are dropped until the next frame_start.
// After reset the position is 0, so bytes count as a frame without a flag.
// A byte is taken every cycle unless in_ch.ready is low. When byte 31 is
// transferred, the header and the sum of bytes 0..29 are checked and the
// twelve words (or zeros with an error status) are copied into a result
// buffer. out_ch carries one measurement word per transfer, each moved
// from the buffer into the output register, one per cycle while out_ch is
// ready, last_field on the twelfth. A result register decouples the two
// channels: bytes of the next frame keep flowing while the burst drains.
// If the receiver stalls, results hold; in_ch.ready drops only while byte
// 31 of the next frame is due and the previous burst is still in the buffer.
// Reset (rst_n low, synchronous) clears position, checksum and the burst.
// ----------------------------------------------------------------------------
module particle_sensor_frame_parser (
  input  wire logic  clk,
  input  wire logic  rst_n,
  psfp_in_if.sink    in_ch,
  psfp_out_if.source out_ch
);

  logic                    done;
  logic                    pending;
  psfp_pkg::frame_result_t result;

  psfp_accum u_accum (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .burst_pending (pending),
    .done          (done),
    .result        (result)
  );

  psfp_burst u_burst (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (done),
    .result  (result),
    .pending (pending),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire
